### rtl/psg_tce_pkg.sv
`timescale 1ns / 1ps
// psg_tce_pkg: item types, constants and the divider step for the PSG tone encoder.
// No dependencies.
package psg_tce_pkg;

  localparam int unsigned PSG_CLOCK = 3579545;
  // floor(floor(clk / 32) / f) == floor(clk / (32 * f))
  localparam int unsigned DIVIDEND_VAL = PSG_CLOCK / 32;
  localparam int DIV_BITS = $clog2(DIVIDEND_VAL + 1);
  localparam logic [DIV_BITS-1:0] DIVIDEND = DIV_BITS'(DIVIDEND_VAL);

  localparam int FREQ_W = 16;
  localparam int TONE_W = 10;

  // request op codes
  localparam logic OP_TONE_VOLUME = 1'b0;
  localparam logic OP_VOLUME_ONLY = 1'b1;

  typedef struct packed {
    logic              op;
    logic [1:0]        channel;
    logic [FREQ_W-1:0] frequency;
    logic [3:0]        volume;
  } psg_tce_req_t;

  typedef struct packed {
    logic [7:0] command_byte;
    logic       last;
  } psg_tce_rsp_t;

  // one item in flight through the divider
  typedef struct packed {
    logic              op;
    logic [1:0]        channel;
    logic [3:0]        atten;
    logic [FREQ_W-1:0] divisor;
    logic [FREQ_W-1:0] rem;
    logic [TONE_W-1:0] quo;
  } psg_tce_work_t;

  // one restoring division step; a zero divisor yields all-ones quotient bits
  function automatic psg_tce_work_t div_step(psg_tce_work_t w, logic dbit);
    logic [FREQ_W:0] shifted;
    logic [FREQ_W:0] diff;
    psg_tce_work_t   r;
    r       = w;
    shifted = {w.rem, dbit};
    diff    = shifted - {1'b0, w.divisor};
    if (shifted >= {1'b0, w.divisor}) begin
      r.rem = diff[FREQ_W-1:0];
      r.quo = {w.quo[TONE_W-2:0], 1'b1};
    end else begin
      r.rem = shifted[FREQ_W-1:0];
      r.quo = {w.quo[TONE_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### rtl/psg_tone_command_encoder_core.sv
`timescale 1ns / 1ps
// Pipeline: ceil(17 / STEPS_PER_STAGE) divider stages plus one byte register.
// STEPS_PER_STAGE defaults to 3. A request can enter every cycle unless the
// serializer or rsp_stall holds the pipeline; the single byte port emits one
// byte a cycle while rsp_stall is low: three for a tone request, one for volume.
// Reset (rst, synchronous) clears all valid bits; no memories to clear.
module psg_tone_command_encoder_core
  import psg_tce_pkg::*;
#(
  parameter int STEPS_PER_STAGE = 3
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  output logic         req_stall,
  input  psg_tce_req_t req,
  output logic         rsp_valid,
  input  logic         rsp_stall,
  output psg_tce_rsp_t rsp
);

  localparam int NUM_STAGES = (DIV_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  typedef enum logic [1:0] {
    BYTE_LATCH,
    BYTE_DATA,
    BYTE_ATTEN
  } byte_sel_t;

  psg_tce_work_t             entry;
  psg_tce_work_t             stage_in  [NUM_STAGES];
  psg_tce_work_t             stage_out [NUM_STAGES];
  psg_tce_work_t             stage     [NUM_STAGES];
  logic [NUM_STAGES-1:0]     vld;
  logic [NUM_STAGES-1:0]     vld_in;
  logic [NUM_STAGES:0]       ready;

  // byte serializer
  logic                      s_valid;
  byte_sel_t                 s_idx;
  logic [1:0]                s_chan;
  logic [3:0]                s_atten;
  logic [TONE_W-1:0]         s_tone;
  logic                      ser_ready;
  logic                      is_last;

  always_comb begin
    entry         = '0;
    entry.op      = req.op;
    entry.channel = req.channel;
    entry.atten   = ~req.volume;
    entry.divisor = req.frequency;
  end

  assign req_stall = !ready[0];

  for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign stage_in[s] = entry;
      assign vld_in[s]   = req_valid;
    end else begin : g_rest
      assign stage_in[s] = stage[s-1];
      assign vld_in[s]   = vld[s-1];
    end

    assign ready[s] = !vld[s] || ready[s+1];

    always_comb begin
      stage_out[s] = stage_in[s];
      for (int k = 0; k < STEPS_PER_STAGE; k++) begin
        if (s * STEPS_PER_STAGE + k < DIV_BITS) begin
          stage_out[s] = div_step(stage_out[s],
                                  DIVIDEND[DIV_BITS - 1 - (s * STEPS_PER_STAGE + k)]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (ready[s]) begin
        vld[s] <= vld_in[s];
      end
      if (ready[s]) begin
        stage[s] <= stage_out[s];
      end
    end
  end

  assign is_last            = (s_idx == BYTE_ATTEN);
  assign ser_ready          = !s_valid || (!rsp_stall && is_last);
  assign ready[NUM_STAGES]  = ser_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_idx   <= BYTE_LATCH;
    end else if (ser_ready) begin
      s_valid <= vld[NUM_STAGES-1];
      s_idx   <= (stage[NUM_STAGES-1].op == OP_VOLUME_ONLY) ? BYTE_ATTEN : BYTE_LATCH;
    end else if (!rsp_stall) begin
      s_idx <= (s_idx == BYTE_LATCH) ? BYTE_DATA : BYTE_ATTEN;
    end
    if (ser_ready) begin
      s_chan  <= stage[NUM_STAGES-1].channel;
      s_atten <= stage[NUM_STAGES-1].atten;
      s_tone  <= stage[NUM_STAGES-1].quo;
    end
  end

  assign rsp_valid = s_valid;

  always_comb begin
    rsp.last = is_last;
    unique case (s_idx)
      BYTE_LATCH: rsp.command_byte = {1'b1, s_chan, 1'b0, s_tone[3:0]};
      BYTE_DATA:  rsp.command_byte = {2'b00, s_tone[TONE_W-1:4]};
      BYTE_ATTEN: rsp.command_byte = {1'b1, s_chan, 1'b1, s_atten};
      default:    rsp.command_byte = '0;
    endcase
  end

endmodule

### rtl/psg_tce_checker.sv
`timescale 1ns / 1ps
// psg_tce_checker: port-level checks on the byte stream of the PSG tone encoder.
// Depends on psg_tce_pkg; bound to psg_tone_command_encoder_core.
module psg_tce_checker
  import psg_tce_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         rsp_valid,
  input logic         rsp_stall,
  input psg_tce_rsp_t rsp
);

  logic       rsp_take;
  logic [1:0] latch_chan;
  assign rsp_take = rsp_valid && !rsp_stall;

  // channel of the most recent latch byte
  always_ff @(posedge clk) begin
    if (rsp_take && rsp.command_byte[7] && !rsp.command_byte[4]) begin
      latch_chan <= rsp.command_byte[6:5];
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("byte valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled byte changed");

  a_last_is_atten: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.last |-> rsp.command_byte[7] && rsp.command_byte[4])
    else $error("final byte is not an attenuation byte");

  // latch byte is followed at once by its data byte
  a_latch_then_data: assert property (@(posedge clk) disable iff (rst)
    rsp_take && !rsp.last && rsp.command_byte[7]
      |=> rsp_valid && !rsp.command_byte[7] && !rsp.last)
    else $error("latch byte not followed by data byte");

  // data byte is followed at once by the attenuation byte of the same channel
  a_data_then_atten: assert property (@(posedge clk) disable iff (rst)
    rsp_take && !rsp.command_byte[7]
      |=> rsp_valid && rsp.last && rsp.command_byte[6:5] == latch_chan)
    else $error("data byte not followed by matching attenuation byte");

endmodule

bind psg_tone_command_encoder_core psg_tce_checker u_psg_tce_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

### tb/sv/psg_tce_checker.sv
`timescale 1ns / 1ps
// psg_tce_scoreboard: watches both channels of the PSG tone encoder, predicts the
// command bytes of every accepted item and compares them in order. Uses psg_tce_pkg.
module psg_tce_scoreboard
  import psg_tce_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  input  logic         req_stall,
  input  psg_tce_req_t req,
  input  logic         rsp_valid,
  input  logic         rsp_stall,
  input  psg_tce_rsp_t rsp,
  output int           mismatches,
  output int           bytes_owed,
  output int           bytes_seen
);

  localparam int unsigned CHIP_CLOCK_HZ = 3579545;

  psg_tce_rsp_t expected_bytes[$];
  int           error_count = 0;
  int           seen_count = 0;

  function automatic logic [9:0] tone_divider(logic [15:0] hz);
    int unsigned divisor;
    divisor = 32'(hz) * 32;
    // zero frequency: no division, lowest pitch
    if (divisor == 0) return '1;
    return 10'(CHIP_CLOCK_HZ / divisor);
  endfunction

  function automatic void encode_request(psg_tce_req_t r);
    logic [9:0]   div;
    psg_tce_rsp_t b;
    if (r.op == OP_TONE_VOLUME) begin
      div = tone_divider(r.frequency);
      b.command_byte = {1'b1, r.channel, 1'b0, div[3:0]};
      b.last = 1'b0;
      expected_bytes.push_back(b);
      b.command_byte = {2'b00, div[9:4]};
      expected_bytes.push_back(b);
    end
    b.command_byte = {1'b1, r.channel, 1'b1, 4'(4'd15 - r.volume)};
    b.last = 1'b1;
    expected_bytes.push_back(b);
  endfunction

  always @(posedge clk) begin
    psg_tce_rsp_t want;
    if (rst) begin
      expected_bytes.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        seen_count++;
        if (expected_bytes.size() == 0) begin
          error_count++;
          $error("unexpected item: command_byte %02h, last %0b", rsp.command_byte, rsp.last);
        end else begin
          want = expected_bytes.pop_front();
          if (rsp.command_byte !== want.command_byte) begin
            error_count++;
            $error("command_byte: expected %02h, actual %02h",
                   want.command_byte, rsp.command_byte);
          end
          if (rsp.last !== want.last) begin
            error_count++;
            $error("last: expected %0b, actual %0b", want.last, rsp.last);
          end
        end
      end
      if (req_valid && !req_stall) encode_request(req);
    end
    // nonblocking so the stimulus side sees values settled at the previous edge
    mismatches <= error_count;
    bytes_owed <= expected_bytes.size();
    bytes_seen <= seen_count;
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for psg_tone_command_encoder_core; prediction and
// comparison live in psg_tce_scoreboard. Uses psg_tce_pkg.
module tb_top
  import psg_tce_pkg::*;
();

  localparam int LONG_HOLD_CYCLES = 120;
  localparam int TAIL_CYCLES = 20;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         req_valid = 1'b0;
  logic         req_stall;
  psg_tce_req_t req = '0;
  logic         rsp_valid;
  logic         rsp_stall = 1'b0;
  psg_tce_rsp_t rsp;

  int mismatches;
  int bytes_owed;
  int bytes_seen;

  bit idling = 1'b1;
  int hold_requests = 0;
  int tone_count = 0;
  int volume_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  psg_tone_command_encoder_core DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  psg_tce_scoreboard u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .mismatches(mismatches),
    .bytes_owed(bytes_owed),
    .bytes_seen(bytes_seen)
  );

  task automatic send_request(input logic op_sel, input logic [1:0] ch,
                              input logic [15:0] hz, input logic [3:0] vol);
    int gap;
    gap = idling ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= '{op: op_sel, channel: ch, frequency: hz, volume: vol};
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    if (op_sel == OP_TONE_VOLUME) tone_count++;
    else volume_count++;
  endtask

  // sender stops offering items until every predicted byte has come out
  task automatic drain_output();
    req_valid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    logic [15:0] hz;
    case ($urandom_range(0, 9))
      0:       hz = '0;
      1, 2, 3: hz = 16'($urandom_range(1, 109));  // dividers past 10 bits
      default: hz = 16'($urandom);
    endcase
    send_request(($urandom_range(0, 9) < 7) ? OP_TONE_VOLUME : OP_VOLUME_ONLY,
                 2'($urandom), hz, 4'($urandom));
  endtask

  // receiver: random stall per item, plus one long hold-off on request
  initial begin : receiver
    int stall_cycles;
    int holds_done;
    holds_done = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_requests != holds_done) begin
        stall_cycles = LONG_HOLD_CYCLES;
        holds_done++;
      end else begin
        stall_cycles = idling ? $urandom_range(0, 8) : 0;
      end
      if (stall_cycles > 0) begin
        rsp_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
        rsp_stall <= 1'b0;
      end
      do @(posedge clk); while (!rsp_valid);
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero frequency, wrapped dividers, top frequency, channel three,
    // volume extremes, volume-only on every channel
    send_request(OP_TONE_VOLUME, 2'd0, 16'd0,     4'd15);
    send_request(OP_TONE_VOLUME, 2'd1, 16'd1,     4'd0);
    send_request(OP_TONE_VOLUME, 2'd2, 16'd65535, 4'd15);
    send_request(OP_TONE_VOLUME, 2'd3, 16'd440,   4'd8);
    send_request(OP_TONE_VOLUME, 2'd0, 16'd109,   4'd7);
    send_request(OP_TONE_VOLUME, 2'd1, 16'd112,   4'd1);
    send_request(OP_TONE_VOLUME, 2'd2, 16'd3,     4'd14);
    send_request(OP_TONE_VOLUME, 2'd3, 16'd0,     4'd0);
    send_request(OP_VOLUME_ONLY, 2'd0, 16'd0,     4'd0);
    send_request(OP_VOLUME_ONLY, 2'd1, 16'd65535, 4'd15);
    send_request(OP_VOLUME_ONLY, 2'd2, 16'd1234,  4'd5);
    send_request(OP_VOLUME_ONLY, 2'd3, 16'd0,     4'd10);
    send_request(OP_TONE_VOLUME, 2'd0, 16'hAAAA,  4'h5);
    send_request(OP_TONE_VOLUME, 2'd1, 16'h5555,  4'hA);
    send_request(OP_TONE_VOLUME, 2'd2, 16'd110,   4'd3);
    send_request(OP_TONE_VOLUME, 2'd3, 16'd65535, 4'd15);
    drain_output();

    // output held off while items keep coming back to back
    idling <= 1'b0;
    hold_requests <= hold_requests + 1;
    repeat (24) send_random_request();
    drain_output();

    // random items, idle gaps on and off in stretches
    for (int chunk = 0; chunk < 6; chunk++) begin
      idling <= (chunk % 2 == 0);
      repeat (13) send_random_request();
      if (chunk == 2) drain_output();
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests (%0d tone, %0d volume only) and %0d output bytes,",
             tone_count + volume_count, tone_count, volume_count, bytes_seen);
    $display("with zero and wrapped dividers, all channels, a long output stall and idle gaps.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("timeout waiting for output bytes");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
rtl/psg_tce_pkg.sv
rtl/psg_tone_command_encoder_core.sv
rtl/psg_tce_checker.sv
tb/sv/psg_tce_checker.sv
tb/sv/tb_top.sv
